[hw/rtl/rgb_to_hsi_pixel_assert.svh]
// Assertion macros for the RGB to HSI converter.
// Included by the RTL modules that check their own behavior.
`ifndef RGB_TO_HSI_PIXEL_ASSERT_SVH
`define RGB_TO_HSI_PIXEL_ASSERT_SVH
`ifndef SYNTH
`define RHSI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define RHSI_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define RHSI_ASSERT(label, clk, rst, prop)
`define RHSI_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

[hw/rtl/rgbhsi_pkg.sv]
// Types and constants shared by the RGB to HSI converter.
// No dependencies.
package rgbhsi_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int ANGLE_BITS   = 32;
   localparam int QUOT_BITS    = 8;
   localparam int REM_BITS     = 18;
   localparam int SUM_BITS     = 10;
   localparam longint SQRT3_Q24 = 64'd29058991;
   localparam logic [ANGLE_BITS-1:0] HALF_TURN = 32'h8000_0000;

   localparam logic [ANGLE_BITS-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] intensity;
   } hsi_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] angle;
      logic [REM_BITS-1:0]   remainder;
      logic [QUOT_BITS-1:0]  quotient;
      logic [SUM_BITS-1:0]   divisor;
      logic [7:0]            intensity;
      logic                  gray;
   } carry_type;

endpackage

[hw/rtl/rgbhsi_cell.sv]
// One stage of the converter chain: a CORDIC vectoring step and,
// in the leading stages, one restoring division step. Uses rgbhsi_pkg.
module rgbhsi_cell #(
   parameter int W    = 28,
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic signed [W-1:0]   in_x,
   input  logic signed [W-1:0]   in_y,
   input  rgbhsi_pkg::carry_type in_carry,
   output logic                  out_valid,
   output logic signed [W-1:0]   out_x,
   output logic signed [W-1:0]   out_y,
   output rgbhsi_pkg::carry_type out_carry
);

   localparam int SH = (STEP < rgbhsi_pkg::QUOT_BITS) ? rgbhsi_pkg::QUOT_BITS - 1 - STEP : 0;

   logic                   valid_ff;
   logic signed [W-1:0]    x_ff, x_in, y_ff, y_in;
   rgbhsi_pkg::carry_type  carry_ff, carry_in;
   logic signed [W-1:0]    xs, ys;
   logic [rgbhsi_pkg::REM_BITS-1:0] den_shift;
   logic [rgbhsi_pkg::REM_BITS:0]   trial;

   always_comb begin
      xs        = in_x >>> STEP;
      ys        = in_y >>> STEP;
      carry_in  = in_carry;
      den_shift = rgbhsi_pkg::REM_BITS'(in_carry.divisor) << SH;
      trial     = {1'b0, in_carry.remainder} - {1'b0, den_shift};
      if (in_y > 0) begin
         x_in = in_x + ys;
         y_in = in_y - xs;
         carry_in.angle = in_carry.angle + rgbhsi_pkg::ATAN_TURNS[STEP];
      end else begin
         x_in = in_x - ys;
         y_in = in_y + xs;
         carry_in.angle = in_carry.angle - rgbhsi_pkg::ATAN_TURNS[STEP];
      end
      if ((STEP < rgbhsi_pkg::QUOT_BITS) && !trial[rgbhsi_pkg::REM_BITS]) begin
         carry_in.remainder    = trial[rgbhsi_pkg::REM_BITS-1:0];
         carry_in.quotient[SH] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         carry_ff <= carry_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_carry = carry_ff;

endmodule

[hw/rtl/rgb_to_hsi_pixel.sv]
// Top level of the RGB to HSI converter: input stage, chain of cells, output register.
// Uses rgbhsi_pkg, rgbhsi_cell and rgb_to_hsi_pixel_assert.svh.
//
// Usage:
//   req_valid/req_stall/req_data carry one pixel (blue, green, red) per transaction.
//   rsp_valid/rsp_stall/rsp_data return hue, saturation and intensity.
//   A transaction happens at a clock edge with valid high and stall low.
// Path: from input transaction to rsp_valid through one input stage,
//   24 CORDIC cells and one output register.
// Throughput: one pixel per clock while the receiver does not stall;
//   every cell takes a new pixel each cycle in which the chain advances.
// Saturation uses a restoring divider spread over the first 8 cells.
// Reset clears all valid bits; no pixel is in flight afterwards.
// When the receiver stalls with a result waiting, the whole chain holds
//   and req_stall goes high until the result is taken.
// Gray pixels give hue 0 and saturation 0.
`include "rgb_to_hsi_pixel_assert.svh"
module rgb_to_hsi_pixel #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rgbhsi_pkg::pixel_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rgbhsi_pkg::hsi_type   rsp_data
);

   localparam int W = FRACTION_BITS + 12;
   localparam int N = rgbhsi_pkg::CORDIC_STEPS;
   localparam logic signed [W-1:0] SQRT3_Q =
      W'(rgbhsi_pkg::SQRT3_Q24 >> (24 - FRACTION_BITS));

   logic advance;

   logic                  v_chain [N+1];
   logic signed [W-1:0]   x_chain [N+1];
   logic signed [W-1:0]   y_chain [N+1];
   rgbhsi_pkg::carry_type c_chain [N+1];

   logic                  a_valid_ff;
   logic signed [W-1:0]   a_x_ff, a_x_in, a_y_ff, a_y_in;
   rgbhsi_pkg::carry_type a_carry_ff, a_carry_in;

   logic [9:0]          sum;
   logic [7:0]          mn;
   logic [9:0]          spread;
   logic [19:0]         inten_prod;
   logic signed [10:0]  diff_x;
   logic signed [8:0]   diff_gb;
   logic signed [W-1:0] x0, y0;

   logic                rsp_valid_ff;
   rgbhsi_pkg::hsi_type rsp_data_ff, rsp_data_in;
   logic [39:0]         hue_prod;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      sum = 10'(req_data.blue) + 10'(req_data.green) + 10'(req_data.red);
      mn  = req_data.red;
      if (req_data.green < mn) begin
         mn = req_data.green;
      end
      if (req_data.blue < mn) begin
         mn = req_data.blue;
      end
      spread     = sum - 10'(mn) - 10'(mn) - 10'(mn);
      inten_prod = 20'(sum) * 20'd683;
      diff_x  = $signed({2'b00, req_data.red, 1'b0}) - $signed({3'b000, req_data.green})
              - $signed({3'b000, req_data.blue});
      diff_gb = $signed({1'b0, req_data.green}) - $signed({1'b0, req_data.blue});
      x0 = W'(diff_x) <<< FRACTION_BITS;
      y0 = W'(diff_gb) * SQRT3_Q;
      a_carry_in.remainder = {spread, 8'b0} - {8'b0, spread};
      a_carry_in.quotient  = '0;
      a_carry_in.divisor   = sum;
      a_carry_in.intensity = inten_prod[18:11];
      a_carry_in.gray      = (req_data.red == req_data.green) &&
                             (req_data.green == req_data.blue);
      if (x0 < 0) begin
         a_x_in = -x0;
         a_y_in = -y0;
         a_carry_in.angle = rgbhsi_pkg::HALF_TURN;
      end else begin
         a_x_in = x0;
         a_y_in = y0;
         a_carry_in.angle = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
      if (advance) begin
         a_x_ff     <= a_x_in;
         a_y_ff     <= a_y_in;
         a_carry_ff <= a_carry_in;
      end
   end

   assign v_chain[0] = a_valid_ff;
   assign x_chain[0] = a_x_ff;
   assign y_chain[0] = a_y_ff;
   assign c_chain[0] = a_carry_ff;

   for (genvar i = 0; i < N; i++) begin : g_cell
      rgbhsi_cell #(.W(W), .STEP(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (v_chain[i]),
         .in_x      (x_chain[i]),
         .in_y      (y_chain[i]),
         .in_carry  (c_chain[i]),
         .out_valid (v_chain[i+1]),
         .out_x     (x_chain[i+1]),
         .out_y     (y_chain[i+1]),
         .out_carry (c_chain[i+1])
      );
   end

   always_comb begin
      hue_prod = {c_chain[N].angle, 8'b0} - {8'b0, c_chain[N].angle};
      rsp_data_in.intensity = c_chain[N].intensity;
      if (c_chain[N].gray) begin
         rsp_data_in.hue        = '0;
         rsp_data_in.saturation = '0;
      end else begin
         rsp_data_in.hue        = hue_prod[39:32];
         rsp_data_in.saturation = c_chain[N].quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v_chain[N];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RHSI_ASSERT(a_accept_lands, clock, reset, (req_valid && !req_stall) |=> a_valid_ff)
   `RHSI_ASSERT(a_hold_on_stall, clock, reset, (a_valid_ff && !advance) |=> a_valid_ff)
   `RHSI_ASSERT(a_rsp_hold, clock, reset,
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
   `RHSI_ASSERT_NEVER(a_gray_hue, clock, reset,
      v_chain[N] && c_chain[N].gray && (rsp_data_in.hue != 8'd0))

endmodule
